FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define TAFIR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tafir check failed");

// Antecedent holds -> consequent holds in the next cycle.
`define TAFIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tafir check failed");

`endif

FILE: rtl/core/tafir_pkg.sv
`default_nettype none
package tafir_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int DESIGN_TAPS  = 47;
  localparam int TAPS_DEF     = 47;
  localparam int COEF_BITS_DEF = 18;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_x;
    logic signed [SAMPLE_BITS-1:0] filtered_y;
    logic signed [SAMPLE_BITS-1:0] filtered_z;
  } out_word_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } line_ctl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Low-pass design in Q1.23.
  localparam logic signed [23:0] DESIGN_Q23 [DESIGN_TAPS] = '{
    24'sd0, 24'sd540, 24'sd2276, 24'sd5445, 24'sd10365, 24'sd17420, 24'sd27029,
    24'sd39606, 24'sd55520, 24'sd75038, 24'sd98281, 24'sd125185, 24'sd155467,
    24'sd188609, 24'sd223863, 24'sd260270, 24'sd296694, 24'sd331883, 24'sd364531,
    24'sd393353, 24'sd417167, 24'sd434960, 24'sd445960, 24'sd449682, 24'sd445960,
    24'sd434960, 24'sd417167, 24'sd393353, 24'sd364531, 24'sd331883, 24'sd296694,
    24'sd260270, 24'sd223863, 24'sd188609, 24'sd155467, 24'sd125185, 24'sd98281,
    24'sd75038, 24'sd55520, 24'sd39606, 24'sd27029, 24'sd17420, 24'sd10365,
    24'sd5445, 24'sd2276, 24'sd540, 24'sd0
  };

  // Round a Q1.23 design tap half up to Q1.(cb-1); taps past the design are zero.
  function automatic logic signed [31:0] coef_q(input int k, input int cb);
    logic signed [31:0] q;
    int s;
    q = 32'sd0;
    s = 24 - cb;
    if (k < DESIGN_TAPS) begin
      q = 32'(DESIGN_Q23[k]);
    end
    if (s > 0) begin
      q = (q + (32'sd1 <<< (s - 1))) >>> s;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tafir_cell.sv
`default_nettype none
module tafir_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire tafir_pkg::in_word_t d,
  output tafir_pkg::in_word_t     q
);

  tafir_pkg::in_word_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule
`default_nettype wire

FILE: rtl/core/tafir_line.sv
`default_nettype none
module tafir_line #(
  parameter int TAPS = tafir_pkg::TAPS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tafir_pkg::line_ctl_t ctl,
  input  wire tafir_pkg::in_word_t  new_word,
  output tafir_pkg::in_word_t      tail
);

  tafir_pkg::in_word_t cell_q [TAPS];
  tafir_pkg::in_word_t head_d;
  logic                shift_en;

  // Insert pushes the newest word in at the head and drops the oldest;
  // rotate wraps the tail back to the head.
  assign head_d   = ctl.insert ? new_word : cell_q[TAPS-1];
  assign shift_en = ctl.insert | ctl.rotate;

  for (genvar g = 0; g < TAPS; g++) begin : g_cell
    if (g == 0) begin : g_head
      tafir_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .d     (head_d),
        .q     (cell_q[g])
      );
    end else begin : g_body
      tafir_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (shift_en),
        .d     (cell_q[g-1]),
        .q     (cell_q[g])
      );
    end
  end

  assign tail = cell_q[TAPS-1];

endmodule
`default_nettype wire

FILE: rtl/core/tafir_mac.sv
`default_nettype none
module tafir_mac #(
  parameter int TAPS      = tafir_pkg::TAPS_DEF,
  parameter int COEF_BITS = tafir_pkg::COEF_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tafir_pkg::mac_ctl_t    ctl,
  input  wire tafir_pkg::in_word_t    sample,
  input  wire logic signed [COEF_BITS-1:0] coef,
  output tafir_pkg::out_word_t        result
);

  localparam int SW    = tafir_pkg::SAMPLE_BITS;
  localparam int PW    = SW + COEF_BITS;
  localparam int ACC_W = PW + $clog2(TAPS) + 1;
  localparam int RW    = ACC_W + 2 - COEF_BITS;
  localparam logic signed [ACC_W:0] RND = (ACC_W + 1)'(1) <<< (COEF_BITS - 2);
  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW - 1){1'b0}}};

  logic signed [SW-1:0]    smp   [3];
  logic signed [PW-1:0]    prod_r [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [SW-1:0]    fin   [3];
  logic                    prod_vld_r;

  assign smp[0] = sample.rate_x;
  assign smp[1] = sample.rate_y;
  assign smp[2] = sample.rate_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.mul_en;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [ACC_W:0]  rnd;
    logic signed [RW-1:0]   sh;
    logic [RW-SW:0]         top;

    always_ff @(posedge clk) begin
      if (ctl.mul_en) begin
        prod_r[a] <= smp[a] * coef;
      end
      if (ctl.clear) begin
        acc_r[a] <= '0;
      end else if (prod_vld_r) begin
        acc_r[a] <= acc_r[a] + ACC_W'(prod_r[a]);
      end
    end

    // Round half up, floor-shift out the fraction, saturate.
    assign rnd = $signed({acc_r[a][ACC_W-1], acc_r[a]}) + RND;
    assign sh  = rnd[ACC_W:COEF_BITS-1];
    assign top = sh[RW-1:SW-1];

    always_comb begin
      if ((&top) || !(|top)) begin
        fin[a] = sh[SW-1:0];
      end else if (sh[RW-1]) begin
        fin[a] = SAT_MIN;
      end else begin
        fin[a] = SAT_MAX;
      end
    end
  end

  assign result.filtered_x = fin[0];
  assign result.filtered_y = fin[1];
  assign result.filtered_z = fin[2];

endmodule
`default_nettype wire

FILE: rtl/core/three_axis_fir_filter.sv
// Three-axis FIR low-pass filter for gyro rate samples.
// Input channel: in_valid / in_stall / in_word carry one (x, y, z) sample word.
// Output channel: out_valid / out_stall / out_word carry the filtered word.
// A word moves on a rising edge where valid is high and stall is low.
// Each accepted word enters the head of a delay line of TAPS cells (the oldest
// word drops out), then the line rotates once around, one cell per cycle,
// while three multiply-accumulate units (one per axis) take the tail cell
// times the matching tap from the constant coefficient table.
// After the rotation, the drain state adds the last product and the done
// state loads the rounded, saturated sum into the output register.
// A new word is taken only once the sequencer is back in idle, after the
// single pass of the rotating delay line through the shared multipliers
// and the load of the previous result.
// in_stall is high from acceptance until the result sits in the output
// register; a new word is taken while that result still waits.
// If the receiver stalls with the output register full, the finished sum
// holds in place and no new word is taken until the register frees up.
// Reset (rst_n low, synchronous) clears the sample history to zero, empties
// the output register and returns the sequencer to idle.
`default_nettype none
`include "assert_macros.svh"
module three_axis_fir_filter #(
  parameter int TAPS      = tafir_pkg::TAPS_DEF,
  parameter int COEF_BITS = tafir_pkg::COEF_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tafir_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tafir_pkg::out_word_t   out_word
);

  localparam int CW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CW-1:0] TAP_LAST = CW'(TAPS - 1);

  tafir_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]        tap_cnt_r, tap_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tafir_pkg::out_word_t out_word_r;

  tafir_pkg::line_ctl_t line_ctl;
  tafir_pkg::mac_ctl_t  mac_ctl;
  tafir_pkg::in_word_t  tail;
  tafir_pkg::out_word_t mac_result;
  logic                 in_take;
  logic                 out_load;

  // Constant tap table, one entry per cell.
  logic signed [COEF_BITS-1:0] coef_tab [TAPS];
  for (genvar g = 0; g < TAPS; g++) begin : g_coef
    assign coef_tab[g] = COEF_BITS'(tafir_pkg::coef_q(g, COEF_BITS));
  end

  assign in_take = in_valid && !in_stall;

  // Next state: one rotation of the line per word, then drain and hand off.
  always_comb begin
    state_nxt   = state_r;
    tap_cnt_nxt = tap_cnt_r;
    case (state_r)
      tafir_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = tafir_pkg::ST_RUN;
          tap_cnt_nxt = TAP_LAST;
        end
      end
      tafir_pkg::ST_RUN: begin
        if (tap_cnt_r == '0) begin
          state_nxt = tafir_pkg::ST_DRAIN;
        end else begin
          tap_cnt_nxt = tap_cnt_r - 1'b1;
        end
      end
      tafir_pkg::ST_DRAIN: begin
        state_nxt = tafir_pkg::ST_DONE;
      end
      tafir_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = tafir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tafir_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall        = 1'b1;
    line_ctl.insert = 1'b0;
    line_ctl.rotate = 1'b0;
    mac_ctl.clear   = 1'b0;
    mac_ctl.mul_en  = 1'b0;
    out_load        = 1'b0;
    case (state_r)
      tafir_pkg::ST_IDLE: begin
        in_stall        = 1'b0;
        line_ctl.insert = in_valid;
        mac_ctl.clear   = in_valid;
      end
      tafir_pkg::ST_RUN: begin
        line_ctl.rotate = 1'b1;
        mac_ctl.mul_en  = 1'b1;
      end
      tafir_pkg::ST_DRAIN: begin
        out_load = 1'b0;
      end
      tafir_pkg::ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Output register: load the finished word, drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tafir_pkg::ST_IDLE;
      tap_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= mac_result;
    end
  end

  tafir_line #(
    .TAPS (TAPS)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (line_ctl),
    .new_word (in_word),
    .tail     (tail)
  );

  tafir_mac #(
    .TAPS      (TAPS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (tail),
    .coef   (coef_tab[tap_cnt_r]),
    .result (mac_result)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the sequencer.
  `TAFIR_ASSERT_NEXT(a_take_starts_run, in_take, (state_r == tafir_pkg::ST_RUN) && (tap_cnt_r == TAP_LAST))
  `TAFIR_ASSERT_NEXT(a_run_counts_down, (state_r == tafir_pkg::ST_RUN) && (tap_cnt_r != '0), (state_r == tafir_pkg::ST_RUN) && (tap_cnt_r == $past(tap_cnt_r) - 1'b1))
  `TAFIR_ASSERT_NEXT(a_load_offers, out_load, out_valid && (state_r == tafir_pkg::ST_IDLE))
  `TAFIR_ASSERT_SAME(a_stall_when_busy, state_r != tafir_pkg::ST_IDLE, in_stall && !line_ctl.insert)

endmodule
`default_nettype wire

FILE: verif/tb_three_axis_fir_filter.sv
module tb_three_axis_fir_filter;

  localparam int TAPS      = tafir_pkg::TAPS_DEF;
  localparam int COEF_BITS = tafir_pkg::COEF_BITS_DEF;
  localparam int SB        = tafir_pkg::SAMPLE_BITS;
  localparam int FRAC      = COEF_BITS - 1;
  localparam int Q23_SHIFT = 24 - COEF_BITS;
  localparam int LP_TAPS   = 47;

  localparam longint SAT_HI = 2**(SB - 1) - 1;
  localparam longint SAT_LO = -(2**(SB - 1));

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

  // Random items after the directed part; the last stretch runs without idling.
  localparam int RANDOM_WORDS = 950;
  localparam int QUIET_FROM   = 800;
  // Long receiver hold-off, and the watchdog limit on cycles with no handshake.
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;

  typedef enum int {
    SEG_NOISE,
    SEG_HOLD,
    SEG_DRIFT,
    SEG_RAMP,
    SEG_TOGGLE,
    SEG_IMPULSE
  } seg_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  tafir_pkg::in_word_t  in_word  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  tafir_pkg::out_word_t out_word;

  // Stimulus and scoreboard state.
  tafir_pkg::in_word_t  rate_queue[$];
  tafir_pkg::out_word_t filtered_due[$];
  bit in_taken    = 1'b0;
  int fail_count  = 0;
  int idle_cycles = 0;

  // Pacing knobs; the stimulus process sets the idle rates per segment.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int tx_gap      = 0;
  int rx_gap      = 0;
  bit hold_go     = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;

  // Predictor state: coefficient taps, sample history, newest slot.
  int                  lp_q23 [LP_TAPS];
  longint              coef [TAPS];
  tafir_pkg::in_word_t history [TAPS];
  int                  newest;

  three_axis_fir_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Round half up out of the fractional bits, then clamp to the sample range.
  function automatic logic [SB-1:0] round_sat(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[SB-1:0];
  endfunction

  // Advance the newest slot, store the word there, and convolve each axis
  // with the taps: tap k meets the sample k steps old.
  function automatic tafir_pkg::out_word_t fir_step(tafir_pkg::in_word_t w);
    longint acc_x, acc_y, acc_z;
    int idx, k;
    tafir_pkg::out_word_t r;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    newest = (newest + 1) % TAPS;
    history[newest] = w;
    for (k = 0; k < TAPS; k++) begin
      idx = (newest + TAPS - k) % TAPS;
      acc_x += coef[k] * longint'($signed(history[idx].rate_x));
      acc_y += coef[k] * longint'($signed(history[idx].rate_y));
      acc_z += coef[k] * longint'($signed(history[idx].rate_z));
    end
    r.filtered_x = round_sat(acc_x);
    r.filtered_y = round_sat(acc_y);
    r.filtered_z = round_sat(acc_z);
    return r;
  endfunction

  function automatic tafir_pkg::in_word_t mk_word(logic [SB-1:0] x, y, z);
    tafir_pkg::in_word_t w;
    w.rate_x = x;
    w.rate_y = y;
    w.rate_z = z;
    return w;
  endfunction

  function automatic logic [SB-1:0] rnd16();
    logic [31:0] v;
    v = $urandom;
    return v[SB-1:0];
  endfunction

  // Full-scale and near-zero values that sit on the edges of the range.
  function automatic logic [SB-1:0] pick_edge();
    case ($urandom_range(4))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return {{(SB - 1){1'b0}}, 1'b1};
    endcase
  endfunction

  // Queue one shaped run of samples and return its length.
  function automatic int add_segment(seg_kind_t kind);
    int n, i;
    logic [31:0] dx, dy, dz;
    logic [SB-1:0] vx, vy, vz;
    tafir_pkg::in_word_t w;
    n = 0;
    case (kind)
      SEG_NOISE: begin
        n = $urandom_range(40, 10);
        for (i = 0; i < n; i++) rate_queue.push_back(mk_word(rnd16(), rnd16(), rnd16()));
      end
      SEG_HOLD: begin
        // hold a level long enough to fill the whole history
        n = $urandom_range(TAPS + 20, TAPS);
        w = mk_word(pick_edge(), pick_edge(), pick_edge());
        for (i = 0; i < n; i++) rate_queue.push_back(w);
      end
      SEG_DRIFT: begin
        // small jitter around a random bias, like a gyro at rest
        n = $urandom_range(60, 20);
        vx = rnd16();
        vy = rnd16();
        vz = rnd16();
        for (i = 0; i < n; i++) begin
          dx = $urandom_range(511) - 256;
          dy = $urandom_range(511) - 256;
          dz = $urandom_range(511) - 256;
          rate_queue.push_back(mk_word(vx + dx[SB-1:0], vy + dy[SB-1:0], vz + dz[SB-1:0]));
        end
      end
      SEG_RAMP: begin
        n = $urandom_range(60, 20);
        vx = rnd16();
        vy = rnd16();
        vz = rnd16();
        dx = $urandom_range(2047);
        dy = $urandom_range(2047);
        dz = $urandom_range(2047);
        for (i = 0; i < n; i++) begin
          vx = vx + dx[SB-1:0];
          vy = vy - dy[SB-1:0];
          vz = vz + dz[SB-1:0];
          rate_queue.push_back(mk_word(vx, vy, vz));
        end
      end
      SEG_TOGGLE: begin
        // alternate between full-scale extremes each word
        n = $urandom_range(60, 20);
        vx = $urandom_range(1) ? S_MAX : S_MIN;
        vy = $urandom_range(1) ? S_MAX : S_MIN;
        vz = $urandom_range(1) ? S_MAX : S_MIN;
        for (i = 0; i < n; i++) begin
          if (i % 2 == 0) rate_queue.push_back(mk_word(vx, vy, vz));
          else rate_queue.push_back(mk_word(~vx, ~vy, ~vz));
        end
      end
      default: begin
        // one edge sample, then zeros until it has walked out of the history
        n = TAPS + 2;
        rate_queue.push_back(mk_word(pick_edge(), pick_edge(), pick_edge()));
        for (i = 1; i < n; i++) rate_queue.push_back('0);
      end
    endcase
    return n;
  endfunction

  // Block until every queued word is taken and every result is back.
  task automatic wait_settled();
    while (rate_queue.size() != 0 || in_valid || filtered_due.size() != 0) @(posedge clk);
  endtask

  // Driver: advance to the next word only once the current one is taken;
  // a stalled word holds its payload.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (rate_queue.size() != 0 && $urandom_range(99) < tx_idle_pct) begin
        tx_gap   <= $urandom_range(5);
        in_valid <= 1'b0;
      end else if (rate_queue.size() != 0) begin
        in_word  <= rate_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off counted here so
  // the block fills up and has to stall its own input.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
      if (hold_left == 1) hold_done <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap    <= rx_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      rx_gap    <= $urandom_range(5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on every accepted input word, check every accepted
  // result word against the oldest prediction.
  always @(posedge clk) begin : monitor
    tafir_pkg::out_word_t due;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) filtered_due.push_back(fir_step(in_word));
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word x=%0d y=%0d z=%0d",
                   $signed(out_word.filtered_x), $signed(out_word.filtered_y),
                   $signed(out_word.filtered_z));
      end else begin
        due = filtered_due.pop_front();
        if (due.filtered_x !== out_word.filtered_x || due.filtered_y !== out_word.filtered_y ||
            due.filtered_z !== out_word.filtered_z) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     $signed(due.filtered_x), $signed(due.filtered_y),
                     $signed(due.filtered_z), $signed(out_word.filtered_x),
                     $signed(out_word.filtered_y), $signed(out_word.filtered_z));
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int k, issued;
    lp_q23 = '{
      0, 540, 2276, 5445, 10365, 17420, 27029, 39606,
      55520, 75038, 98281, 125185, 155467, 188609, 223863, 260270,
      296694, 331883, 364531, 393353, 417167, 434960, 445960, 449682,
      445960, 434960, 417167, 393353, 364531, 331883, 296694, 260270,
      223863, 188609, 155467, 125185, 98281, 75038, 55520, 39606,
      27029, 17420, 10365, 5445, 2276, 540, 0
    };
    // Requantize the Q1.23 design to the tap width, rounding half up;
    // taps past the design are zero.
    for (k = 0; k < TAPS; k++) begin
      coef[k] = 0;
      if (k < LP_TAPS) begin
        coef[k] = lp_q23[k];
        if (Q23_SHIFT > 0) coef[k] = (coef[k] + (longint'(1) <<< (Q23_SHIFT - 1))) >>> Q23_SHIFT;
      end
      history[k] = '0;
    end
    newest = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: range edges on each axis, sign-bit and alternating patterns.
    rate_queue.push_back(mk_word(S_MAX, S_MIN, '0));
    rate_queue.push_back(mk_word(S_MIN, S_MAX, '1));
    rate_queue.push_back(mk_word({{(SB - 1){1'b0}}, 1'b1}, '1, S_MAX));
    rate_queue.push_back(mk_word('0, '0, S_MIN));
    rate_queue.push_back(mk_word(S_MAX, S_MAX, S_MAX));
    rate_queue.push_back(mk_word(S_MAX, S_MAX, S_MAX));
    rate_queue.push_back(mk_word(S_MIN, S_MIN, S_MIN));
    rate_queue.push_back(mk_word(16'h5555, 16'hAAAA, 16'h00FF));
    rate_queue.push_back(mk_word(16'hAAAA, 16'h5555, 16'hFF00));
    rate_queue.push_back(mk_word('1, '1, '1));
    rate_queue.push_back(mk_word('0, '0, '0));
    rate_queue.push_back(mk_word(16'h8001, 16'h7FFE, 16'h0100));
    wait_settled();

    // Pressure: stall the receiver hard while words keep coming, then let
    // the sender wait until every result has drained.
    hold_go = 1'b1;
    repeat (6) rate_queue.push_back(mk_word(rnd16(), rnd16(), rnd16()));
    while (!hold_done) @(posedge clk);
    wait_settled();

    // Random part: full-scale holds first to drive both saturation limits,
    // then shaped segments with varying idle rates.
    issued = 2 * (TAPS + 8);
    repeat (TAPS + 8) rate_queue.push_back(mk_word(S_MAX, S_MIN, S_MAX));
    repeat (TAPS + 8) rate_queue.push_back(mk_word(S_MIN, S_MAX, S_MIN));
    while (issued < RANDOM_WORDS) begin
      while (rate_queue.size() != 0) @(posedge clk);
      if (issued >= QUIET_FROM) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 20 * $urandom_range(2);
        rx_idle_pct = 20 * $urandom_range(2);
      end
      issued += add_segment(seg_kind_t'($urandom_range(SEG_IMPULSE)));
    end

    wait_settled();
    repeat (TAPS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
